@@ hdl/sds_pkg.sv @@
`timescale 1ns / 1ps

package sds_pkg;

    // Fixed field widths of the stream payloads
    localparam int VALUE_W  = 20;
    localparam int TDATA_W  = 24;
    localparam int TUSER_W  = 2;
    localparam int THRESH_W = 31;

    // Register reset and parameter defaults
    localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd1024;
    localparam int MAX_ITEMS_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 20;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS_START,
        ST_FETCH,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PASS_END,
        ST_FINISH
    } sds_state_t;

endpackage

@@ hdl/sds_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle; done pulses after the last iteration.
module sds_div #(
    parameter int W = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic         rem_nonzero
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          q_bit;
    logic [W:0]    quo_shift;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[W-1]};
        diff      = trial - {1'b0, dsr_reg};
        q_bit     = (trial >= {1'b0, dsr_reg});
        rem_next  = q_bit ? diff[W-1:0] : trial[W-1:0];
        quo_shift = {quo_reg, q_bit};
        quo_next  = quo_shift[W-1:0];
    end

    // Control: count steps, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then iterate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done        = done_reg;
    assign quotient    = quo_reg;
    assign rem_nonzero = (rem_reg != '0);

endmodule

@@ hdl/smallest_divisor_search.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake                Payload
// s_*      in   s_tvalid / s_tready      s_tdata[19:0] value, s_tlast marks the final value
// m_*      out  m_tvalid / m_tready      m_tdata[19:0] divisor, m_tuser[0] found, [1] dropped
// cfg_*    in   cfg_valid / cfg_ready    cfg_data[30:0] threshold
//
// A value that is not last is stored while the block stays idle. A last value starts a
// binary search of about ceil(log2(largest value + 1)) passes over the value memory; each
// pass divides every stored value by the candidate in the one-bit-per-cycle divider. Input
// is held off during the search. Reset clears the counters and the threshold to 1024; the
// value memory needs no clearing. A result waiting on m_tready holds the sequencer before
// its output register is reloaded.
module smallest_divisor_search #(
    parameter int MAX_ITEMS  = sds_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS = sds_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sds_pkg::TDATA_W-1:0]  s_tdata,   // [19:0] value
    input  logic                         s_tlast,   // last value of the set
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sds_pkg::TDATA_W-1:0]  m_tdata,   // [19:0] divisor
    output logic [sds_pkg::TUSER_W-1:0]  m_tuser,   // [0] found, [1] dropped
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sds_pkg::THRESH_W-1:0] cfg_data   // [30:0] threshold
);

    import sds_pkg::*;

    localparam int VB     = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int SW     = VB + 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int TOT_W  = VB + CNT_W;
    localparam int CMP_W  = (TOT_W > THRESH_W) ? TOT_W : THRESH_W;

    sds_state_t state_reg, state_next;

    logic [THRESH_W-1:0] thresh_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [VB-1:0]       largest_reg;
    logic                overflow_reg;
    logic                dropped_reg;
    logic [SW-1:0]       low_reg;
    logic [SW-1:0]       high_reg;
    logic [SW-1:0]       mid_reg;
    logic [VB-1:0]       best_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [VB-1:0]       rd_data_reg;

    logic                m_tvalid_reg;
    logic [VB-1:0]       m_div_reg;
    logic                m_found_reg;
    logic                m_dropped_reg;

    logic [VB-1:0]       value_store [MAX_ITEMS];

    logic                in_xfer;
    logic                room;
    logic [VB-1:0]       in_value;
    logic [VB-1:0]       largest_next;
    logic [SW:0]         mid_sum;
    logic [CNT_W-1:0]    idx_inc;
    logic                fits;
    logic                out_load;
    logic                div_start;
    logic                div_done;
    logic [VB-1:0]       div_quo;
    logic                div_rem_nz;

    // Input decode
    assign in_xfer      = s_tvalid && s_tready;
    assign room         = (count_reg < CNT_W'(MAX_ITEMS));
    assign in_value     = s_tdata[VB-1:0];
    assign largest_next = (room && (in_value > largest_reg)) ? in_value : largest_reg;
    assign mid_sum      = {1'b0, low_reg} + {1'b0, high_reg};
    assign idx_inc      = idx_reg + 1'b1;
    assign fits         = (CMP_W'(total_reg) <= CMP_W'(thresh_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_xfer && s_tlast)
                    state_next = ST_PASS_START;
            ST_PASS_START:
                state_next = (low_reg > high_reg) ? ST_FINISH : ST_FETCH;
            ST_FETCH:
                state_next = ST_DIV_START;
            ST_DIV_START:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_done)
                    state_next = (idx_inc == count_reg) ? ST_PASS_END : ST_FETCH;
            ST_PASS_END:
                state_next = ST_PASS_START;
            ST_FINISH:
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:      s_tready  = 1'b1;
            ST_DIV_START: div_start = 1'b1;
            ST_FINISH:    out_load  = !m_tvalid_reg || m_tready;
            default:      ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            thresh_reg   <= THRESH_RESET;
            count_reg    <= '0;
            largest_reg  <= '0;
            overflow_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
                thresh_reg <= cfg_data;

            // Load a value, or note the overflow
            if (in_xfer)
            begin
                if (room)
                    count_reg <= count_reg + 1'b1;
                else
                    overflow_reg <= 1'b1;
                largest_reg <= largest_next;
            end

            // Drop the loaded set once the result is taken into the output register
            if (out_load)
            begin
                count_reg    <= '0;
                largest_reg  <= '0;
                overflow_reg <= 1'b0;
            end

            // Output register handshake
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Search datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_xfer && s_tlast)
                begin
                    low_reg     <= SW'(1);
                    high_reg    <= (largest_next != '0) ? {1'b0, largest_next} : SW'(1);
                    best_reg    <= '0;
                    dropped_reg <= overflow_reg || !room;
                end
            ST_PASS_START:
            begin
                mid_reg   <= mid_sum[SW:1];
                idx_reg   <= '0;
                total_reg <= '0;
            end
            ST_DIV_WAIT:
                if (div_done)
                begin
                    total_reg <= total_reg + TOT_W'(div_quo) + TOT_W'(div_rem_nz);
                    idx_reg   <= idx_inc;
                end
            ST_PASS_END:
                if (fits)
                begin
                    best_reg <= mid_reg[VB-1:0];
                    high_reg <= mid_reg - 1'b1;
                end
                else
                begin
                    low_reg <= mid_reg + 1'b1;
                end
            default: ;
        endcase

        if (out_load)
        begin
            m_div_reg     <= best_reg;
            m_found_reg   <= (best_reg != '0);
            m_dropped_reg <= dropped_reg;
        end
    end

    // Value memory: write on load, registered read per fetch
    always_ff @(posedge clk)
    begin
        if (in_xfer && room)
            value_store[count_reg[ADDR_W-1:0]] <= in_value;
        if (state_reg == ST_FETCH)
            rd_data_reg <= value_store[idx_reg[ADDR_W-1:0]];
    end

    sds_div #(
        .W (VB)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend    (rd_data_reg),
        .divisor     (mid_reg[VB-1:0]),
        .done        (div_done),
        .quotient    (div_quo),
        .rem_nonzero (div_rem_nz)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = TDATA_W'(m_div_reg);
    assign m_tuser   = {m_dropped_reg, m_found_reg};

endmodule
